>>> rtl/slgf_pkg.sv
// ----------------------------------------------------------------------------
// slgf_pkg
// Shared widths, constants and types of the scheduled linear gain fader.
// ----------------------------------------------------------------------------
package slgf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 14;
    localparam int GAIN_BITS      = 16;
    localparam int DELAY_BITS     = 32;
    localparam int LEN_BITS       = 24;
    localparam int RECIP_FRAC     = 24;
    localparam int RECIP_BITS     = RECIP_FRAC + 1;
    // (goal - start) times ramp position, plus the start term
    localparam int ACC_BITS       = GAIN_BITS + 1 + RECIP_BITS + 1;

    localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(64'd1 << GAIN_FRAC_BITS);
    localparam logic [RECIP_BITS-1:0] Q24_ONE    = RECIP_BITS'(64'd1 << RECIP_FRAC);
    localparam logic [ACC_BITS-1:0]   Q24_HALF   = ACC_BITS'(64'd1 << (RECIP_FRAC - 1));

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic [GAIN_BITS-1:0]          target_gain;
        logic [DELAY_BITS-1:0]         start_delay;
        logic [LEN_BITS-1:0]           ramp_samples;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic [GAIN_BITS-1:0]          gain_now;
        logic                          fading;
        logic                          ramp_finished;
    } t_out_item;

    typedef struct packed {
        logic                 load;
        logic [GAIN_BITS-1:0] gain;
    } t_lane_ctrl;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain_now;
        logic                 fading;
        logic                 ramp_finished;
    } t_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/slgf_if.sv
// ----------------------------------------------------------------------------
// slgf_if
// Valid/ready channels carrying fader requests and results.
// ----------------------------------------------------------------------------
interface slgf_in_if;
    logic                valid;
    logic                ready;
    slgf_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slgf_out_if;
    logic                valid;
    logic                ready;
    slgf_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/slgf_recip.sv
// ----------------------------------------------------------------------------
// slgf_recip
// Restoring divider: floor(2^24 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slgf_recip (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [slgf_pkg::LEN_BITS-1:0]       i_den,
    output slgf_pkg::t_div_stat                 o_stat,
    output logic [slgf_pkg::RECIP_BITS-1:0]     o_quot
);

    localparam int LW = slgf_pkg::LEN_BITS;
    localparam int QW = slgf_pkg::RECIP_BITS;
    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [LW-1:0] r_den;
    logic [LW-1:0] r_rem;
    logic [QW-1:0] r_dvd;
    logic [QW-1:0] r_quot;

    logic [LW:0]   w_trial;
    logic          w_fit;
    logic [LW:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= '0;
            r_dvd  <= slgf_pkg::Q24_ONE;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[LW-1:0] : w_trial[LW-1:0];
            r_dvd  <= {r_dvd[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], w_fit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

>>> rtl/slgf_lane.sv
// ----------------------------------------------------------------------------
// slgf_lane
// One channel: sample times gain, rounded and saturated.
// ----------------------------------------------------------------------------
module slgf_lane (
    input  logic                                   i_clk,
    input  slgf_pkg::t_lane_ctrl                   i_ctrl,
    input  logic signed [slgf_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [slgf_pkg::SAMPLE_BITS-1:0] o_sample
);

    localparam int SW     = slgf_pkg::SAMPLE_BITS;
    localparam int PROD_W = SW + slgf_pkg::GAIN_BITS + 1;
    localparam int RND_W  = PROD_W + 1;
    localparam logic signed [RND_W-1:0] ROUND_BIAS =
        RND_W'(64'd1 << (slgf_pkg::GAIN_FRAC_BITS - 1));
    localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    logic signed [RND_W-1:0]  w_sum;
    logic signed [RND_W-1:0]  w_q;
    logic                     w_in_range;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= PROD_W'(i_sample) * $signed({1'b0, i_ctrl.gain});
        end
    end

    assign w_sum = RND_W'(r_prod) + ROUND_BIAS;
    assign w_q   = w_sum >>> slgf_pkg::GAIN_FRAC_BITS;

    // fits when every bit above the sample's sign bit copies it
    assign w_in_range = (&w_q[RND_W-1:SW-1]) | ~(|w_q[RND_W-1:SW-1]);

    always_comb begin
        if (w_in_range) begin
            o_sample = w_q[SW-1:0];
        end else if (w_q[RND_W-1]) begin
            o_sample = SAT_MIN;
        end else begin
            o_sample = SAT_MAX;
        end
    end

endmodule

>>> rtl/slgf_merge.sv
// ----------------------------------------------------------------------------
// slgf_merge
// Joins both lanes and the gain status into one result held for the sink.
// ----------------------------------------------------------------------------
module slgf_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic signed [slgf_pkg::SAMPLE_BITS-1:0] i_left,
    input  logic signed [slgf_pkg::SAMPLE_BITS-1:0] i_right,
    input  slgf_pkg::t_status                       i_status,
    output logic                                    o_free,
    slgf_out_if.source                              o_out
);

    logic                r_valid;
    slgf_pkg::t_out_item r_item;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.left_out      <= i_left;
            r_item.right_out     <= i_right;
            r_item.gain_now      <= i_status.gain_now;
            r_item.fading        <= i_status.fading;
            r_item.ramp_finished <= i_status.ramp_finished;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

endmodule

>>> rtl/scheduled_linear_gain_fader_top.sv
// ----------------------------------------------------------------------------
// scheduled_linear_gain_fader_top
// Stereo gain fader with delayed linear ramps to a commanded target gain.
// ----------------------------------------------------------------------------
// A request is either a fade command or a stereo frame. A command keeps
// further requests waiting until the bit-serial reciprocal divider is
// done (one quotient bit per cycle, 25 bits); it gives no result. A frame
// outside a ramp, or on the last ramp step where the goal is forced, goes
// through accept, lane multiply and result load; any other ramp step adds
// three steps before the lane multiply: the ramp position multiply, the
// interpolation multiply and the final add. Both channels are scaled by
// their own lane at once. A finished result sits in the output register
// while the next request is taken; if it is still unclaimed when the next
// result is due, the block waits for it.
// ----------------------------------------------------------------------------
module scheduled_linear_gain_fader_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slgf_in_if.sink    i_in,
    slgf_out_if.source o_out
);

    localparam int GW = slgf_pkg::GAIN_BITS;
    localparam int LW = slgf_pkg::LEN_BITS;
    localparam int DW = slgf_pkg::DELAY_BITS;
    localparam int QW = slgf_pkg::RECIP_BITS;
    localparam int AW = slgf_pkg::ACC_BITS;
    localparam int PW = LW + QW;

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'b001,
        MODE_PENDING = 3'b010,
        MODE_RAMPING = 3'b100
    } t_mode;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_INT  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_GAIN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                 r_state,    n_state;
    t_mode                  r_mode,     n_mode;
    logic [GW-1:0]          r_gain,     n_gain;
    logic [GW-1:0]          r_start,    n_start;
    logic [GW-1:0]          r_goal,     n_goal;
    logic [DW-1:0]          r_delay,    n_delay;
    logic [LW-1:0]          r_count,    n_count;
    logic [LW-1:0]          r_len,      n_len;
    logic [QW-1:0]          r_recip,    n_recip;
    logic [LW-1:0]          r_k,        n_k;
    logic [QW-1:0]          r_p,        n_p;
    logic signed [AW-1:0]   r_prod,     n_prod;
    logic                   r_fading,   n_fading;
    logic                   r_finished, n_finished;
    logic signed [slgf_pkg::SAMPLE_BITS-1:0] r_left;
    logic signed [slgf_pkg::SAMPLE_BITS-1:0] r_right;

    logic                   w_in_acc;
    logic                   w_cmd_acc;
    logic [LW-1:0]          w_len;
    logic                   w_pend_start;
    logic [LW-1:0]          w_kcur;
    logic                   w_last_step;
    logic [PW-1:0]          w_p_full;
    logic signed [GW:0]     w_diff;
    logic signed [AW-1:0]   w_base;
    logic signed [AW-1:0]   w_acc;
    logic                   w_free;
    logic                   w_merge_load;
    slgf_pkg::t_div_stat    w_div_stat;
    logic [QW-1:0]          w_quot;
    slgf_pkg::t_lane_ctrl   w_lane_ctrl;
    slgf_pkg::t_status      w_status;
    logic signed [slgf_pkg::SAMPLE_BITS-1:0] w_left_out;
    logic signed [slgf_pkg::SAMPLE_BITS-1:0] w_right_out;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_cmd_acc  = w_in_acc && i_in.data.action;

    assign w_len = (i_in.data.ramp_samples == '0) ? LW'(1) : i_in.data.ramp_samples;

    // a pending fade whose delay has run out starts ramping on this frame
    assign w_pend_start = (r_mode == MODE_PENDING) && (r_delay == '0);
    assign w_kcur       = w_pend_start ? '0 : r_count;
    assign w_last_step  = (({1'b0, w_kcur} + (LW + 1)'(1)) >= {1'b0, r_len});

    assign w_p_full = PW'(r_k) * PW'(r_recip);
    assign w_diff   = $signed({1'b0, r_goal}) - $signed({1'b0, r_start});
    assign w_base   = $signed(AW'({r_start, {slgf_pkg::RECIP_FRAC{1'b0}}}));
    assign w_acc    = r_prod + w_base + $signed(slgf_pkg::Q24_HALF);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_gain     = r_gain;
        n_start    = r_start;
        n_goal     = r_goal;
        n_delay    = r_delay;
        n_count    = r_count;
        n_len      = r_len;
        n_recip    = r_recip;
        n_k        = r_k;
        n_p        = r_p;
        n_prod     = r_prod;
        n_fading   = r_fading;
        n_finished = r_finished;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in.data.action) begin
                    n_goal  = i_in.data.target_gain;
                    n_delay = i_in.data.start_delay;
                    n_len   = w_len;
                    n_count = '0;
                    n_mode  = MODE_PENDING;
                    n_state = S_DIV;
                end else if (w_in_acc) begin
                    n_finished = 1'b0;
                    n_state    = S_GAIN;
                    if (w_pend_start) begin
                        n_start = r_gain;
                    end
                    if (w_pend_start || (r_mode == MODE_RAMPING)) begin
                        if (w_last_step) begin
                            n_gain     = r_goal;
                            n_count    = r_len;
                            n_mode     = MODE_STANDBY;
                            n_fading   = 1'b0;
                            n_finished = 1'b1;
                        end else begin
                            n_k      = w_kcur;
                            n_count  = w_kcur + LW'(1);
                            n_mode   = MODE_RAMPING;
                            n_fading = 1'b1;
                            n_state  = S_MUL;
                        end
                    end else if (r_mode == MODE_PENDING) begin
                        n_delay  = r_delay - DW'(1);
                        n_fading = 1'b1;
                    end else begin
                        n_mode   = MODE_STANDBY;
                        n_fading = 1'b0;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_recip = w_quot;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_p     = (w_p_full > PW'(slgf_pkg::Q24_ONE)) ? slgf_pkg::Q24_ONE
                                                             : w_p_full[QW-1:0];
                n_state = S_INT;
            end
            S_INT: begin
                n_prod  = AW'(w_diff) * $signed({1'b0, r_p});
                n_state = S_ADD;
            end
            S_ADD: begin
                n_gain  = w_acc[slgf_pkg::RECIP_FRAC +: GW];
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_STANDBY;
            r_gain     <= slgf_pkg::GAIN_UNITY;
            r_start    <= '0;
            r_goal     <= '0;
            r_delay    <= '0;
            r_count    <= '0;
            r_len      <= LW'(1);
            r_recip    <= '0;
            r_fading   <= 1'b0;
            r_finished <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_gain     <= n_gain;
            r_start    <= n_start;
            r_goal     <= n_goal;
            r_delay    <= n_delay;
            r_count    <= n_count;
            r_len      <= n_len;
            r_recip    <= n_recip;
            r_fading   <= n_fading;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_p    <= n_p;
        r_prod <= n_prod;
        if (w_in_acc) begin
            r_left  <= i_in.data.left_in;
            r_right <= i_in.data.right_in;
        end
    end

    slgf_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmd_acc),
        .i_den   (w_len),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    assign w_lane_ctrl.load = (r_state == S_GAIN);
    assign w_lane_ctrl.gain = r_gain;

    slgf_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctrl   (w_lane_ctrl),
        .i_sample (r_left),
        .o_sample (w_left_out)
    );

    slgf_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctrl   (w_lane_ctrl),
        .i_sample (r_right),
        .o_sample (w_right_out)
    );

    assign w_status.gain_now      = r_gain;
    assign w_status.fading        = r_fading;
    assign w_status.ramp_finished = r_finished;
    assign w_merge_load           = (r_state == S_OUT) && w_free;

    slgf_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_merge_load),
        .i_left   (w_left_out),
        .i_right  (w_right_out),
        .i_status (w_status),
        .o_free   (w_free),
        .o_out    (o_out)
    );

    // lane products must have been captured before a result is loaded
    a_out_after_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ($past(r_state == S_GAIN) || $past(r_state == S_OUT)))
        else $error("result stage entered without lane multiply");

    a_finished_not_fading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.ramp_finished) |-> !o_out.data.fading)
        else $error("finished ramp still reported as fading");

    a_ramp_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INT) |-> (r_p <= slgf_pkg::Q24_ONE))
        else $error("ramp position beyond one");

    a_no_accept_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> !i_in.ready)
        else $error("request taken while reciprocal in progress");

endmodule

>>> tb/sv/scheduled_linear_gain_fader_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scheduled_linear_gain_fader_top_tb
// Self-checking bench for the stereo gain fader. A short table of directed
// requests covers reset gain, saturation, zero-length and maximum-length
// ramps, long delays and fade commands that cut in. A long run of random
// fade sequences follows. Every frame result is checked against a
// cycle-free model of the gain ramp and the sample scaling, or against the
// expected result given in its table row.
module scheduled_linear_gain_fader_top_tb;

    localparam int  HALF_PERIOD  = 6;
    localparam int  LIMIT_CYCLES = 800000;
    localparam int  RAND_ITEMS   = 1750;
    localparam int  SETTLE       = 40;
    localparam int  MAX_REPORTS  = 10;

    localparam int SAMPLE_BITS    = slgf_pkg::SAMPLE_BITS;
    localparam int GAIN_BITS      = slgf_pkg::GAIN_BITS;
    localparam int GAIN_FRAC_BITS = slgf_pkg::GAIN_FRAC_BITS;
    localparam int DELAY_BITS     = slgf_pkg::DELAY_BITS;
    localparam int LEN_BITS       = slgf_pkg::LEN_BITS;
    localparam int RECIP_FRAC     = slgf_pkg::RECIP_FRAC;
    localparam int RECIP_BITS     = slgf_pkg::RECIP_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = slgf_pkg::GAIN_UNITY;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_FADE  = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [GAIN_BITS-1:0]          G_MAX = '1;

    typedef longint unsigned t_u64;

    typedef enum logic [2:0] {
        FADE_IDLE    = 3'b001,
        FADE_PENDING = 3'b010,
        FADE_RAMPING = 3'b100
    } t_fade_mode;

    typedef struct {
        slgf_pkg::t_in_item  req;
        bit                  typed;
        slgf_pkg::t_out_item want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    slgf_in_if  req_if ();
    slgf_out_if res_if ();

    scheduled_linear_gain_fader_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // fader model state
    t_fade_mode            fm_mode;
    logic [GAIN_BITS-1:0]  fm_gain;
    logic [GAIN_BITS-1:0]  fm_start;
    logic [GAIN_BITS-1:0]  fm_goal;
    logic [DELAY_BITS-1:0] fm_delay;
    logic [LEN_BITS-1:0]   fm_count;
    logic [LEN_BITS-1:0]   fm_len;
    logic [RECIP_BITS-1:0] fm_recip;

    slgf_pkg::t_out_item gained_q[$];
    t_dir_row            dir_tab[$];
    int                  n_bad;
    int                  pace;
    int                  burst_left;

    function automatic void fader_reset();
        fm_mode  = FADE_IDLE;
        fm_gain  = GAIN_UNITY;
        fm_start = '0;
        fm_goal  = '0;
        fm_delay = '0;
        fm_count = '0;
        fm_len   = LEN_BITS'(1);
        fm_recip = '0;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(
        input logic signed [SAMPLE_BITS-1:0] s,
        input logic [GAIN_BITS-1:0]          g
    );
        longint prod;
        longint hi;
        longint lo;
        hi   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo   = -hi - 1;
        prod = longint'(s) * longint'({1'b0, g}) + (longint'(1) <<< (GAIN_FRAC_BITS - 1));
        prod = prod >>> GAIN_FRAC_BITS;     // floor, rounding bias already added
        if (prod > hi) prod = hi;
        if (prod < lo) prod = lo;
        return SAMPLE_BITS'(prod);
    endfunction

    function automatic logic [GAIN_BITS-1:0] ramp_point();
        t_u64 pos;
        t_u64 acc;
        t_u64 one;
        one = t_u64'(1) << RECIP_FRAC;
        pos = t_u64'(fm_count) * t_u64'(fm_recip);
        if (pos > one) pos = one;
        acc = t_u64'(fm_goal) * pos + t_u64'(fm_start) * (one - pos) + (one >> 1);
        return GAIN_BITS'(acc >> RECIP_FRAC);
    endfunction

    // Returns 1 when the request yields a result (frames only).
    function automatic bit fader_step(input slgf_pkg::t_in_item r,
                                      output slgf_pkg::t_out_item res);
        logic                finished;
        logic [LEN_BITS-1:0] len;
        finished = 1'b0;
        res      = '0;
        if (r.action == ACT_FADE) begin
            len      = (r.ramp_samples == '0) ? LEN_BITS'(1) : r.ramp_samples;
            fm_goal  = r.target_gain;
            fm_delay = r.start_delay;
            fm_len   = len;
            fm_recip = RECIP_BITS'((t_u64'(1) << RECIP_FRAC) / t_u64'(len));
            fm_count = '0;
            fm_mode  = FADE_PENDING;
            return 1'b0;
        end
        if (fm_mode == FADE_PENDING) begin
            if (fm_delay == '0) begin
                fm_mode  = FADE_RAMPING;
                fm_start = fm_gain;
                fm_count = '0;
            end else begin
                fm_delay = fm_delay - 1'b1;
            end
        end
        if (fm_mode == FADE_RAMPING) begin
            if (t_u64'(fm_count) + 1 >= t_u64'(fm_len)) begin
                fm_gain  = fm_goal;     // last step lands on the goal exactly
                fm_count = fm_len;
                fm_mode  = FADE_IDLE;
                finished = 1'b1;
            end else begin
                fm_gain  = ramp_point();
                fm_count = fm_count + 1'b1;
            end
        end else if (fm_mode != FADE_PENDING) begin
            fm_mode = FADE_IDLE;
        end
        res.left_out      = apply_gain(r.left_in, fm_gain);
        res.right_out     = apply_gain(r.right_in, fm_gain);
        res.gain_now      = fm_gain;
        res.fading        = (fm_mode == FADE_PENDING) || (fm_mode == FADE_RAMPING);
        res.ramp_finished = finished;
        return 1'b1;
    endfunction

    function automatic slgf_pkg::t_in_item mk_req(
        input logic                          act,
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input logic [GAIN_BITS-1:0]          tgt,
        input logic [DELAY_BITS-1:0]         dly,
        input logic [LEN_BITS-1:0]           len
    );
        slgf_pkg::t_in_item it;
        it.action       = act;
        it.left_in      = l;
        it.right_in     = r;
        it.target_gain  = tgt;
        it.start_delay  = dly;
        it.ramp_samples = len;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return G_MAX;
            2:       return GAIN_UNITY;
            default: return GAIN_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // frame with junk in the command fields, which the block must ignore
    function automatic slgf_pkg::t_in_item rand_frame();
        return mk_req(ACT_FRAME, rand_sample(), rand_sample(), GAIN_BITS'($urandom),
                      $urandom, LEN_BITS'($urandom));
    endfunction

    task automatic send_req(input slgf_pkg::t_in_item r, input bit typed,
                            input slgf_pkg::t_out_item want);
        slgf_pkg::t_out_item res;
        int                  gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (pace == 0) ? 0 : (pace == 1) ? $urandom_range(0, 3) : $urandom_range(1, 20);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!req_if.ready);
        if (fader_step(r, res))
            gained_q.push_back(typed ? want : res);
    endtask

    // hold the sender off until every outstanding frame has come back
    task automatic await_drain();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (gained_q.size() != 0);
        burst_left = 0;
    endtask

    // receiver: ready follows a 32-bit pattern stepped bit by bit, redrawn once all of it is used
    logic [31:0]         stall_pat;
    int                  pat_pos;
    slgf_pkg::t_out_item got;
    slgf_pkg::t_out_item want_r;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            pat_pos = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (gained_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("unexpected result: %p", got);
                end else begin
                    want_r = gained_q.pop_front();
                    if (got.left_out !== want_r.left_out
                        || got.right_out !== want_r.right_out
                        || got.gain_now !== want_r.gain_now
                        || got.fading !== want_r.fading
                        || got.ramp_finished !== want_r.ramp_finished) begin
                        n_bad++;
                        if (n_bad <= MAX_REPORTS)
                            $display({"mismatch: exp L=%0d R=%0d g=%0d f=%0b d=%0b,",
                                      " got L=%0d R=%0d g=%0d f=%0b d=%0b"},
                                     want_r.left_out, want_r.right_out, want_r.gain_now,
                                     want_r.fading, want_r.ramp_finished,
                                     got.left_out, got.right_out, got.gain_now,
                                     got.fading, got.ramp_finished);
                    end
                end
            end
            if (pat_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = $urandom | $urandom;
                    2:       stall_pat = $urandom;
                    default: stall_pat = $urandom & $urandom;
                endcase
            end
            res_if.ready <= stall_pat[pat_pos];
            pat_pos = (pat_pos + 1) % 32;
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("scheduled_linear_gain_fader_top regression: fail");
        $finish;
    end

    initial begin
        int         n_rand;
        int         seg_mark;
        int         n_frames;
        bit         mid_drained;
        bit         with_cmd;
        logic [DELAY_BITS-1:0] dly;
        logic [LEN_BITS-1:0]   len;

        n_bad       = 0;
        pace        = 1;
        burst_left  = 0;
        n_rand      = 0;
        seg_mark    = 0;
        mid_drained = 1'b0;
        fader_reset();

        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; typed rows are reset gain and full-scale saturation
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b1,
                           slgf_pkg::t_out_item'{S_MAX, S_MIN, GAIN_UNITY, 1'b0, 1'b0}});
        dir_tab.push_back('{mk_req(ACT_FRAME, '0, '0, G_MAX, '1, '1), 1'b1,
                           slgf_pkg::t_out_item'{'0, '0, GAIN_UNITY, 1'b0, 1'b0}});
        // zero-length fade to full gain, sample fields junk
        dir_tab.push_back('{mk_req(ACT_FADE, 24'sh123456, '1, G_MAX, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b1,
                           slgf_pkg::t_out_item'{S_MAX, S_MIN, G_MAX, 1'b0, 1'b1}});
        dir_tab.push_back('{mk_req(ACT_FRAME, 24'sd1, '1, '0, '0, '0), 1'b0, '0});
        // delay of two, then a four-step ramp down to silence
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, '0, 32'd2, 24'd4), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, 24'sh100000, -24'sh0abcde, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, 24'sh100000, -24'sh0abcde, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, -24'sd3, 24'sd3, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        // ramp up, cut short by a one-step fade after a delay of one
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, GAIN_UNITY, '0, 24'd5), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, 24'sh3fffff, -24'sh400000, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, 16'd8192, 32'd1, 24'd1), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        // longest delay and length, then replaced while still pending
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, G_MAX, '1, '1), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, 24'sd1, '1, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, '0, '0, '1), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FRAME, S_MAX, S_MIN, '0, '0, '0), 1'b0, '0});
        dir_tab.push_back('{mk_req(ACT_FADE, '0, '0, GAIN_UNITY, '0, 24'd2), 1'b0, '0});

        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        await_drain();

        // random fade sequences; most run through delay and ramp to the end
        while (n_rand < RAND_ITEMS) begin
            if (n_rand >= seg_mark) begin
                pace     = $urandom_range(0, 2);
                seg_mark = n_rand + $urandom_range(100, 300);
            end
            if (!mid_drained && n_rand >= RAND_ITEMS / 2) begin
                await_drain();
                mid_drained = 1'b1;
            end
            with_cmd = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    // full-range fade, usually abandoned early
                    dly      = $urandom;
                    len      = LEN_BITS'($urandom);
                    n_frames = $urandom_range(0, 3);
                end
                1: begin
                    with_cmd = 1'b0;
                    dly      = '0;
                    len      = '0;
                    n_frames = $urandom_range(1, 6);
                end
                default: begin
                    dly = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200)
                                                       : $urandom_range(0, 4);
                    len = ($urandom_range(0, 15) == 0) ? LEN_BITS'($urandom_range(25, 300))
                                                       : LEN_BITS'($urandom_range(0, 12));
                    n_frames = int'(dly) + ((len == '0) ? 1 : int'(len)) + $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0)
                        n_frames = $urandom_range(0, n_frames);
                end
            endcase
            if (with_cmd) begin
                send_req(mk_req(ACT_FADE, rand_sample(), rand_sample(), rand_gain(), dly, len),
                         1'b0, '0);
                n_rand++;
            end
            repeat (n_frames) begin
                send_req(rand_frame(), 1'b0, '0);
                n_rand++;
            end
        end

        await_drain();
        repeat (SETTLE) @(posedge clk);

        if (n_bad == 0)
            $display("scheduled_linear_gain_fader_top regression: pass");
        else
            $display("scheduled_linear_gain_fader_top regression: fail");
        $finish;
    end

endmodule
